FILE: src/array_bst_insert_and_inorder_defines.svh
// ----------------------------------------------------------------------------
// array_bst_insert_and_inorder_defines
// assertion macros used by the tree sorter rtl
// ----------------------------------------------------------------------------
`ifndef ARRAY_BST_INSERT_AND_INORDER_DEFINES_SVH
`define ARRAY_BST_INSERT_AND_INORDER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define ABST_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression that must never be true outside reset
`define ABST_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: src/abst_pkg.sv
// ----------------------------------------------------------------------------
// abst_pkg
// types and constants of the implicit-array search tree sorter
// ----------------------------------------------------------------------------
package abst_pkg;

  localparam int TableSlots = 64;
  localparam int IdxW       = $clog2(TableSlots);
  localparam int ChildW     = IdxW + 1;
  localparam int PowSlots   = 1 << IdxW;
  localparam int ValueBits  = 16;

  typedef logic [IdxW-1:0]             idx_t;
  typedef logic [ChildW-1:0]           child_t;
  typedef logic signed [ValueBits-1:0] val_t;

  localparam logic ActInsert = 1'b0;
  localparam logic ActDump   = 1'b1;

  typedef enum logic [1:0] {
    StStored  = 2'd0,
    StDropped = 2'd1,
    StListed  = 2'd2,
    StEmpty   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SInsChk,
    SInsCmp,
    SDumpDown,
    SDumpRd,
    SDumpUp
  } state_e;

endpackage

FILE: src/array_bst_insert_and_inorder.sv
// insert: the walk alternates a slot check and a read-and-compare per level until a
//   free slot is found and stored (root is depth 0); a walk past depth 5 is dropped.
// dump: listed values come out in order as the walk descends and climbs; an empty
//   tree answers in the cycle after the request.
// busy until the final result shows; results cannot be stalled, one-cycle strobes.
// reset clears the valid bits at once, no clearing pass; value ram is not reset.
// ----------------------------------------------------------------------------
// array_bst_insert_and_inorder
// implicit-array binary search tree with insert and in-order listing
// ----------------------------------------------------------------------------
`include "array_bst_insert_and_inorder_defines.svh"

module array_bst_insert_and_inorder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action_i,
  input  abst_pkg::val_t        value_i,
  output logic                  strobe_o,
  output abst_pkg::val_t        out_value_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);
  import abst_pkg::*;

  state_e state_q, state_d;
  idx_t   node_q, node_d;
  val_t   val_q, val_d;
  val_t   prev_q, prev_d;
  logic   have_prev_q, have_prev_d;
  logic [PowSlots-1:0] valid_q;

  logic    strobe_q;
  val_t    out_value_q;
  status_e status_q;
  logic    last_q;

  logic    emit;
  val_t    emit_val;
  status_e emit_status;
  logic    emit_last;

  logic   mem_we, mem_re;
  idx_t   mem_addr;
  val_t   rd_data;

  logic   accept;
  child_t lc, rc, ins_child;
  logic   lc_ok, rc_ok, node_valid;

  assign accept     = start && (state_q == SIdle);
  assign lc         = {node_q, 1'b0};
  assign rc         = {node_q, 1'b1};
  assign lc_ok      = (lc < child_t'(TableSlots)) && valid_q[lc[IdxW-1:0]];
  assign rc_ok      = (rc < child_t'(TableSlots)) && valid_q[rc[IdxW-1:0]];
  assign node_valid = valid_q[node_q];
  // equal values go right
  assign ins_child  = (rd_data > val_q) ? lc : rc;

  abst_ram #(
    .Depth(TableSlots),
    .Width(ValueBits)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(val_q),
    .rdata_o(rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (action_i == ActDump) begin
            state_d = valid_q[1] ? SDumpDown : SIdle;
          end else begin
            state_d = SInsChk;
          end
        end
      end
      SInsChk:   state_d = node_valid ? SInsCmp : SIdle;
      SInsCmp:   state_d = (ins_child < child_t'(TableSlots)) ? SInsChk : SIdle;
      SDumpDown: state_d = lc_ok ? SDumpDown : SDumpRd;
      SDumpRd:   state_d = rc_ok ? SDumpDown : SDumpUp;
      SDumpUp: begin
        if (node_q == idx_t'(1)) begin
          state_d = SIdle;
        end else if (node_q[0]) begin
          state_d = SDumpUp;
        end else begin
          state_d = SDumpRd;
        end
      end
      default:   state_d = SIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    node_d      = node_q;
    val_d       = val_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = node_q;
    emit        = 1'b0;
    emit_val    = val_q;
    emit_status = StStored;
    emit_last   = 1'b1;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          node_d      = idx_t'(1);
          val_d       = value_i;
          have_prev_d = 1'b0;
          if (action_i == ActDump && !valid_q[1]) begin
            emit        = 1'b1;
            emit_val    = '0;
            emit_status = StEmpty;
          end
        end
      end
      SInsChk: begin
        if (node_valid) begin
          mem_re = 1'b1;
        end else begin
          mem_we      = 1'b1;
          emit        = 1'b1;
          emit_status = StStored;
        end
      end
      SInsCmp: begin
        if (ins_child < child_t'(TableSlots)) begin
          node_d = ins_child[IdxW-1:0];
        end else begin
          emit        = 1'b1;
          emit_status = StDropped;
        end
      end
      SDumpDown: begin
        if (lc_ok) begin
          node_d = lc[IdxW-1:0];
        end else begin
          // visit this node: list the one before it, fetch its value
          mem_re      = 1'b1;
          emit        = have_prev_q;
          emit_val    = prev_q;
          emit_status = StListed;
          emit_last   = 1'b0;
        end
      end
      SDumpRd: begin
        prev_d      = rd_data;
        have_prev_d = 1'b1;
        if (rc_ok) begin
          node_d = rc[IdxW-1:0];
        end
      end
      SDumpUp: begin
        emit_val    = prev_q;
        emit_status = StListed;
        if (node_q == idx_t'(1)) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end else if (node_q[0]) begin
          node_d = node_q >> 1;
        end else begin
          // left child climbs to its parent, which comes next in order
          node_d    = node_q >> 1;
          mem_addr  = node_q >> 1;
          mem_re    = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      have_prev_q <= 1'b0;
      valid_q     <= '0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      strobe_q    <= emit;
      if (mem_we) begin
        valid_q[node_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    val_q  <= val_d;
    prev_q <= prev_d;
    if (emit) begin
      out_value_q <= emit_val;
      status_q    <= emit_status;
      last_q      <= emit_last;
    end
  end

  assign busy        = (state_q != SIdle);
  assign strobe_o    = strobe_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `ABST_CHECK(a_busy_strobe_listed, strobe_o && busy |-> status_o == StListed && !last_o, "strobe while busy is not a non-final listed value")
  `ABST_NEVER(a_overwrite_valid, mem_we && node_valid, "write into an occupied slot")
  `ABST_NEVER(a_node_zero, busy && node_q == '0, "walk reached slot zero")
  `ABST_CHECK(a_insert_goes_busy, accept && action_i == ActInsert |=> busy, "insert request did not start a walk")

endmodule

FILE: src/abst_ram.sv
// ----------------------------------------------------------------------------
// abst_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module abst_ram #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
